>>> rtl/core/ffr_pkg.sv
// ----------------------------------------------------------------------------
// ffr_pkg
// Shared types and constants for the feedback frame receiver.
// ----------------------------------------------------------------------------
package ffr_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned STATUS_W = 2;

    localparam logic [DATA_W-1:0] SYNC_BYTE = 8'hFF;

    // frame_status codes
    localparam logic [STATUS_W-1:0] ST_BODY   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADSUM = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADHDR = 2'd3;

    typedef enum logic [3:0] {
        PH_SYNC1 = 4'b0001,
        PH_SYNC2 = 4'b0010,
        PH_LEN   = 4'b0100,
        PH_BODY  = 4'b1000
    } t_phase;

    // word held in the input register
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] data;
    } t_in_word;

endpackage

>>> rtl/core/feedback_frame_receiver.sv
// ----------------------------------------------------------------------------
// feedback_frame_receiver
// Byte-serial deframer for sync/length/body/checksum feedback frames.
// ----------------------------------------------------------------------------
// Takes one received byte per clock and gives at most one result word per
// byte: an input register feeds the parser, whose combinational decode
// loads the result register. The rate is one byte per cycle, set by the
// parser's phase/count/sum update; o_rx_ready drops only while the result
// register holds a word that downstream has not taken. Sync bytes and a
// nonzero length byte produce no result. Each body byte comes out with
// status 0; the checksum byte ends the frame with status 1 (ok) or 2 (bad);
// a zero length gives status 2 at once, and a wrong sync byte gives status
// 3, after which the parser waits for a new first sync byte.
module feedback_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_frame_valid,
    input  logic       i_frame_ready,
    output logic [7:0] o_frame_byte,
    output logic [1:0] o_frame_status,
    output logic       o_frame_end
);
    import ffr_pkg::*;

    t_in_word w_word;
    logic     w_take;

    ffr_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_rx_byte  (i_rx_byte),
        .i_take     (w_take),
        .o_word     (w_word)
    );

    ffr_parse u_parse (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (w_word),
        .o_take         (w_take),
        .o_frame_valid  (o_frame_valid),
        .i_frame_ready  (i_frame_ready),
        .o_frame_byte   (o_frame_byte),
        .o_frame_status (o_frame_status),
        .o_frame_end    (o_frame_end)
    );

endmodule

>>> rtl/core/ffr_in_stage.sv
// ----------------------------------------------------------------------------
// ffr_in_stage
// Input register for received serial bytes; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module ffr_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_rx_valid,
    output logic                  o_rx_ready,
    input  logic [7:0]            i_rx_byte,
    input  logic                  i_take,
    output ffr_pkg::t_in_word     o_word
);
    import ffr_pkg::*;

    logic              r_valid;
    logic              n_valid;
    logic [DATA_W-1:0] r_data;

    assign o_rx_ready = !r_valid || i_take;

    always_comb begin
        n_valid = r_valid;
        if (o_rx_ready) begin
            n_valid = i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rx_ready && i_rx_valid) begin
            r_data <= i_rx_byte;
        end
    end

    assign o_word.valid = r_valid;
    assign o_word.data  = r_data;

endmodule

>>> rtl/core/ffr_parse.sv
// ----------------------------------------------------------------------------
// ffr_parse
// Frame parser state and result register: sync check, length, running sum,
// checksum compare.
// ----------------------------------------------------------------------------
module ffr_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ffr_pkg::t_in_word     i_word,
    output logic                  o_take,
    output logic                  o_frame_valid,
    input  logic                  i_frame_ready,
    output logic [7:0]            o_frame_byte,
    output logic [1:0]            o_frame_status,
    output logic                  o_frame_end
);
    import ffr_pkg::*;

    t_phase              r_phase, n_phase;
    logic [DATA_W-1:0]   r_left,  n_left;
    logic [DATA_W-1:0]   r_sum,   n_sum;

    logic                r_out_valid, n_out_valid;
    logic [DATA_W-1:0]   r_out_byte;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_end;

    logic                res_valid;
    logic [STATUS_W-1:0] res_status;
    logic                res_end;

    assign o_take = i_word.valid && (!r_out_valid || i_frame_ready);

    always_comb begin
        n_phase    = r_phase;
        n_left     = r_left;
        n_sum      = r_sum;
        res_valid  = 1'b0;
        res_status = ST_BODY;
        res_end    = 1'b0;
        unique case (r_phase)
            PH_SYNC1, PH_SYNC2: begin
                if (i_word.data != SYNC_BYTE) begin
                    n_phase    = PH_SYNC1;
                    res_valid  = 1'b1;
                    res_status = ST_BADHDR;
                    res_end    = 1'b1;
                end else begin
                    n_phase = (r_phase == PH_SYNC1) ? PH_SYNC2 : PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_word.data == '0) begin
                    n_phase    = PH_SYNC1;
                    n_left     = '0;
                    n_sum      = '0;
                    res_valid  = 1'b1;
                    res_status = ST_BADSUM;
                    res_end    = 1'b1;
                end else begin
                    n_left  = i_word.data;
                    n_sum   = i_word.data;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                res_valid = 1'b1;
                if (r_left <= 8'd1) begin
                    // checksum byte closes the frame
                    n_phase    = PH_SYNC1;
                    n_left     = '0;
                    n_sum      = '0;
                    res_status = (i_word.data == ~r_sum) ? ST_OK : ST_BADSUM;
                    res_end    = 1'b1;
                end else begin
                    n_sum  = r_sum + i_word.data;
                    n_left = r_left - 8'd1;
                end
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take) begin
            n_out_valid = res_valid;
        end else if (i_frame_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_left      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_phase <= n_phase;
                r_left  <= n_left;
                r_sum   <= n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && res_valid) begin
            r_out_byte   <= i_word.data;
            r_out_status <= res_status;
            r_out_end    <= res_end;
        end
    end

    assign o_frame_valid  = r_out_valid;
    assign o_frame_byte   = r_out_byte;
    assign o_frame_status = r_out_status;
    assign o_frame_end    = r_out_end;

endmodule

>>> rtl/core/ffr_checker.sv
// ----------------------------------------------------------------------------
// ffr_checker
// Port-level checks for the feedback frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module ffr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_rx_valid,
    input logic       o_rx_ready,
    input logic       o_frame_valid,
    input logic       i_frame_ready,
    input logic [7:0] o_frame_byte,
    input logic [1:0] o_frame_status,
    input logic       o_frame_end
);
    import ffr_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid && !i_frame_ready |=>
            o_frame_valid && $stable(o_frame_byte) && $stable(o_frame_status)
            && $stable(o_frame_end))
        else $error("result word changed while stalled");

    // end flag marks exactly the closing statuses
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid |-> (o_frame_end == (o_frame_status != ST_BODY)))
        else $error("frame_end disagrees with frame_status");

    // a header error is only raised by a non-sync byte
    a_badhdr_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_valid && o_frame_status == ST_BADHDR |-> o_frame_byte != SYNC_BYTE)
        else $error("bad header reported on a sync byte");

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_frame_valid)
        else $error("result valid after reset");

    // with nothing stored, the input side is ready
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rx_valid) && !o_frame_valid && $past(!o_frame_valid) && $past(i_rst_n)
            |-> o_rx_ready)
        else $error("input not ready while block is empty");

endmodule

bind feedback_frame_receiver ffr_checker u_ffr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rx_valid     (i_rx_valid),
    .o_rx_ready     (o_rx_ready),
    .o_frame_valid  (o_frame_valid),
    .i_frame_ready  (i_frame_ready),
    .o_frame_byte   (o_frame_byte),
    .o_frame_status (o_frame_status),
    .o_frame_end    (o_frame_end)
);
